[rtl/two_axis_gain_scheduled_incremental_pid_assert.svh]
// Assertion macros shared by the controller's RTL files.
`ifndef TWO_AXIS_GAIN_SCHEDULED_INCREMENTAL_PID_ASSERT_SVH
`define TWO_AXIS_GAIN_SCHEDULED_INCREMENTAL_PID_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define GSPID_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gspid assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define GSPID_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gspid assertion failed");

`endif

[rtl/gspid_pkg.sv]
// Shared types and constants of the two-axis gain-scheduled PID controller.
package gspid_pkg;

  localparam int DATA_W     = 16;
  localparam int THRESH_W   = 15;
  localparam int GAIN_W     = 16;
  localparam int REGS_W     = 48;
  localparam int INDEX_W    = 3;
  localparam int GAIN_SHIFT = 12;

  localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(256);

  localparam logic signed [DATA_W-1:0] CMD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] CMD_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [INDEX_W-1:0] {
    REG_THRESHOLD  = 3'd0,
    REG_PITCH_FAR  = 3'd1,
    REG_PITCH_NEAR = 3'd2,
    REG_YAW_FAR    = 3'd3,
    REG_YAW_NEAR   = 3'd4
  } reg_index_t;

  // One gain set as packed in a register: kd in the top, kp in the bottom.
  typedef struct packed {
    logic signed [GAIN_W-1:0] kd;
    logic signed [GAIN_W-1:0] ki;
    logic signed [GAIN_W-1:0] kp;
  } gains_t;

  typedef struct packed {
    logic [THRESH_W-1:0] threshold;
    gains_t              pitch_far;
    gains_t              pitch_near;
    gains_t              yaw_far;
    gains_t              yaw_near;
  } cfg_t;

endpackage

[rtl/gspid_ifs.sv]
// Valid/ready channels carrying error samples in and commands out.
interface gspid_err_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [gspid_pkg::DATA_W-1:0]    pitch_error;
  logic signed [gspid_pkg::DATA_W-1:0]    yaw_error;

  modport source (output valid, output pitch_error, output yaw_error, input ready);
  modport sink   (input valid, input pitch_error, input yaw_error, output ready);
endinterface

interface gspid_cmd_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [gspid_pkg::DATA_W-1:0]    pitch_command;
  logic signed [gspid_pkg::DATA_W-1:0]    yaw_command;

  modport source (output valid, output pitch_command, output yaw_command, input ready);
  modport sink   (input valid, input pitch_command, input yaw_command, output ready);
endinterface

[rtl/gspid_cfg.sv]
// Configuration registers: threshold and four gain sets.
module gspid_cfg (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 wr_en,
  input  logic [gspid_pkg::INDEX_W-1:0]        wr_index,
  input  logic [gspid_pkg::REGS_W-1:0]         wr_data,
  output gspid_pkg::cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold  <= gspid_pkg::THRESH_RESET;
      cfg.pitch_far  <= '0;
      cfg.pitch_near <= '0;
      cfg.yaw_far    <= '0;
      cfg.yaw_near   <= '0;
    end else if (wr_en) begin
      // Writes to indexes past the last register are dropped.
      case (wr_index)
        gspid_pkg::REG_THRESHOLD:  cfg.threshold  <= wr_data[gspid_pkg::THRESH_W-1:0];
        gspid_pkg::REG_PITCH_FAR:  cfg.pitch_far  <= wr_data;
        gspid_pkg::REG_PITCH_NEAR: cfg.pitch_near <= wr_data;
        gspid_pkg::REG_YAW_FAR:    cfg.yaw_far    <= wr_data;
        gspid_pkg::REG_YAW_NEAR:   cfg.yaw_near   <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

[rtl/gspid_axis.sv]
// One axis: gain selection, incremental PID update and saturation.
module gspid_axis (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 fire,
  input  logic signed [gspid_pkg::DATA_W-1:0]  e,
  input  logic [gspid_pkg::THRESH_W-1:0]       threshold,
  input  gspid_pkg::gains_t                    far_gains,
  input  gspid_pkg::gains_t                    near_gains,
  output logic signed [gspid_pkg::DATA_W-1:0]  command
);

  `include "two_axis_gain_scheduled_incremental_pid_assert.svh"

  localparam int DW    = gspid_pkg::DATA_W;
  localparam int GW    = gspid_pkg::GAIN_W;
  localparam int SH    = gspid_pkg::GAIN_SHIFT;
  localparam int D1_W  = DW + 1;
  localparam int D2_W  = DW + 2;
  localparam int PP_W  = GW + D1_W;
  localparam int PI_W  = GW + DW;
  localparam int PD_W  = GW + D2_W;
  localparam int SUM_W = PD_W - SH + 3;

  logic signed [DW-1:0] prev_error;
  logic signed [DW-1:0] prev2_error;

  logic [D1_W-1:0]           mag;
  logic                      use_far;
  gspid_pkg::gains_t         g;
  logic signed [D1_W-1:0]    d1;
  logic signed [D2_W-1:0]    d2;
  logic signed [PP_W-1:0]    prod_p;
  logic signed [PI_W-1:0]    prod_i;
  logic signed [PD_W-1:0]    prod_d;
  logic signed [PP_W-SH-1:0] term_p;
  logic signed [PI_W-SH-1:0] term_i;
  logic signed [PD_W-SH-1:0] term_d;
  logic signed [SUM_W-1:0]   sum;
  logic signed [DW-1:0]      command_next;

  always_comb begin
    // The most negative error has magnitude 2^15, which needs the extra bit.
    mag     = e[DW-1] ? D1_W'(-D1_W'(e)) : D1_W'(e);
    use_far = mag > D1_W'(threshold);
    g       = use_far ? far_gains : near_gains;
    d1      = D1_W'(e) - D1_W'(prev_error);
    d2      = D2_W'(e) - (D2_W'(prev_error) <<< 1) + D2_W'(prev2_error);
    prod_p  = g.kp * d1;
    prod_i  = g.ki * e;
    prod_d  = g.kd * d2;
    // Dropping the low bits of a signed product is a floor shift.
    term_p  = prod_p[PP_W-1:SH];
    term_i  = prod_i[PI_W-1:SH];
    term_d  = prod_d[PD_W-1:SH];
    sum     = SUM_W'(term_p) + SUM_W'(term_i) + SUM_W'(term_d) + SUM_W'(command);
    if (sum > SUM_W'(gspid_pkg::CMD_MAX)) begin
      command_next = gspid_pkg::CMD_MAX;
    end else if (sum < SUM_W'(gspid_pkg::CMD_MIN)) begin
      command_next = gspid_pkg::CMD_MIN;
    end else begin
      command_next = sum[DW-1:0];
    end
  end

  // The stored last command doubles as the result register of this axis.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_error  <= '0;
      prev2_error <= '0;
      command     <= '0;
    end else if (fire) begin
      prev2_error <= prev_error;
      prev_error  <= e;
      command     <= command_next;
    end
  end

  `GSPID_ASSERT_NXT(a_hist_shift, fire, prev2_error == $past(prev_error))
  `GSPID_ASSERT_NXT(a_hist_load, fire, prev_error == $past(e))
  `GSPID_ASSERT_NXT(a_cmd_hold, !fire, $stable(command) && $stable(prev_error))

endmodule

[rtl/two_axis_gain_scheduled_incremental_pid.sv]
// Top level of the two-axis gain-scheduled incremental PID controller.
//
// Channels: err takes one beat per control step carrying the pitch and yaw
// errors (signed Q7.8); cmd returns one beat per error beat carrying the new
// saturated pitch and yaw commands (signed Q7.8), in order.
// Configuration: wr_en/wr_index/wr_data write the threshold (index 0) and the
// pitch far, pitch near, yaw far and yaw near gain sets (indexes 1 to 4);
// other indexes are ignored. Write only while no beat is in flight.
// Path: an error beat taken on err is held in the input register until the
// result slot is free or draining, then its commands are registered on cmd.
// Throughput: one beat per cycle while cmd takes beats; the compute stage is a
// single pass through the three parallel multipliers and adder of each axis.
// Stalls: while cmd is held off, the command beat stays put and at most one
// further error beat is buffered, after which err.ready drops.
// Reset: clears the error history and last commands to zero, the threshold
// to 256 and all gains to zero.
module two_axis_gain_scheduled_incremental_pid (
  input  logic                            clk,
  input  logic                            rst,
  gspid_err_if.sink                       err,
  gspid_cmd_if.source                     cmd,
  input  logic                            wr_en,
  input  logic [gspid_pkg::INDEX_W-1:0]   wr_index,
  input  logic [gspid_pkg::REGS_W-1:0]    wr_data
);

  `include "two_axis_gain_scheduled_incremental_pid_assert.svh"

  gspid_pkg::cfg_t cfg;

  logic                                  in_valid;
  logic signed [gspid_pkg::DATA_W-1:0]   in_pitch;
  logic signed [gspid_pkg::DATA_W-1:0]   in_yaw;
  logic                                  out_valid;
  logic                                  fire;

  // Compute when an input is held and the result slot is free or draining.
  assign fire      = in_valid && (!out_valid || cmd.ready);
  assign err.ready = !in_valid || fire;
  assign cmd.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (err.ready) begin
        in_valid <= err.valid;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (cmd.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (err.valid && err.ready) begin
      in_pitch <= err.pitch_error;
      in_yaw   <= err.yaw_error;
    end
  end

  gspid_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  gspid_axis u_pitch (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .e          (in_pitch),
    .threshold  (cfg.threshold),
    .far_gains  (cfg.pitch_far),
    .near_gains (cfg.pitch_near),
    .command    (cmd.pitch_command)
  );

  gspid_axis u_yaw (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .e          (in_yaw),
    .threshold  (cfg.threshold),
    .far_gains  (cfg.yaw_far),
    .near_gains (cfg.yaw_near),
    .command    (cmd.yaw_command)
  );

  `GSPID_ASSERT_NXT(a_fire_gives_beat, fire, out_valid)
  `GSPID_ASSERT_IMP(a_no_overwrite, out_valid && !cmd.ready, !fire)
  `GSPID_ASSERT_IMP(a_ready_only_full, !err.ready, in_valid && out_valid && !cmd.ready)
  `GSPID_ASSERT_NXT(a_idle_drains, !in_valid && cmd.ready, !out_valid)

endmodule

[dv/gspid_command_checker.sv]
// Checker that predicts the controller's command beats and compares them as they leave.
`timescale 1ns / 1ps
module gspid_command_checker
  import gspid_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  gspid_err_if               err,
  gspid_cmd_if               cmd,
  input  logic               wr_en,
  input  logic [INDEX_W-1:0] wr_index,
  input  logic [REGS_W-1:0]  wr_data,
  output int                 mismatches,
  output int                 outstanding,
  output int                 compared
);

  typedef logic signed [39:0]       acc_t;
  typedef logic signed [DATA_W-1:0] sample_t;

  typedef struct packed {
    sample_t e1;
    sample_t e2;
    sample_t last;
  } history_t;

  typedef struct packed {
    sample_t pitch;
    sample_t yaw;
  } command_pair_t;

  cfg_t          regs;
  history_t      pitch_hist;
  history_t      yaw_hist;
  command_pair_t pending_cmds[$];
  int            fail_count = 0;
  int            beat_count = 0;

  // New command of one axis: gain set chosen on |e|, then the velocity-form sum.
  function automatic sample_t next_command(input sample_t e, input history_t h,
                                           input gains_t far_set, input gains_t near_set,
                                           input logic [THRESH_W-1:0] thr);
    acc_t   ev;
    acc_t   mag;
    acc_t   d1;
    acc_t   d2;
    acc_t   sum;
    gains_t g;
    ev  = acc_t'(e);
    mag = (ev < 0) ? -ev : ev;
    g   = (mag > acc_t'(thr)) ? far_set : near_set;
    d1  = ev - acc_t'(h.e1);
    d2  = ev - acc_t'(h.e1) * 2 + acc_t'(h.e2);
    // Arithmetic shifts on signed values floor toward minus infinity.
    sum = ((acc_t'($signed(g.kp)) * d1) >>> GAIN_SHIFT)
        + ((acc_t'($signed(g.ki)) * ev) >>> GAIN_SHIFT)
        + ((acc_t'($signed(g.kd)) * d2) >>> GAIN_SHIFT)
        + acc_t'(h.last);
    if (sum > acc_t'(CMD_MAX)) return CMD_MAX;
    if (sum < acc_t'(CMD_MIN)) return CMD_MIN;
    return sum[DATA_W-1:0];
  endfunction

  always @(posedge clk) begin
    command_pair_t want;
    if (rst) begin
      regs           = '0;
      regs.threshold = THRESH_RESET;
      pitch_hist     = '0;
      yaw_hist       = '0;
      pending_cmds.delete();
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_THRESHOLD:  regs.threshold  = wr_data[THRESH_W-1:0];
          REG_PITCH_FAR:  regs.pitch_far  = wr_data;
          REG_PITCH_NEAR: regs.pitch_near = wr_data;
          REG_YAW_FAR:    regs.yaw_far    = wr_data;
          REG_YAW_NEAR:   regs.yaw_near   = wr_data;
          default: ;
        endcase
      end
      // A result leaves only after its error beat was taken, so pop before push.
      if (cmd.valid && cmd.ready) begin
        if (pending_cmds.size() == 0) begin
          $error("command beat with no error beat outstanding: pitch %0d, yaw %0d",
                 cmd.pitch_command, cmd.yaw_command);
          fail_count++;
        end else begin
          want = pending_cmds.pop_front();
          beat_count++;
          if (cmd.pitch_command !== want.pitch) begin
            $error("pitch_command: expected %0d, got %0d", want.pitch, cmd.pitch_command);
            fail_count++;
          end
          if (cmd.yaw_command !== want.yaw) begin
            $error("yaw_command: expected %0d, got %0d", want.yaw, cmd.yaw_command);
            fail_count++;
          end
        end
      end
      if (err.valid && err.ready) begin
        want.pitch = next_command(err.pitch_error, pitch_hist, regs.pitch_far,
                                  regs.pitch_near, regs.threshold);
        want.yaw   = next_command(err.yaw_error, yaw_hist, regs.yaw_far,
                                  regs.yaw_near, regs.threshold);
        pitch_hist = '{e1: err.pitch_error, e2: pitch_hist.e1, last: want.pitch};
        yaw_hist   = '{e1: err.yaw_error, e2: yaw_hist.e1, last: want.yaw};
        pending_cmds.push_back(want);
      end
    end
    mismatches  <= fail_count;
    outstanding <= pending_cmds.size();
    compared    <= beat_count;
  end

endmodule

[dv/two_axis_gain_scheduled_incremental_pid_test.sv]
// Testbench top: drives error beats, gain settings and back-pressure, and gives the verdict.
`timescale 1ns / 1ps
module two_axis_gain_scheduled_incremental_pid_test;
  import gspid_pkg::*;

  typedef logic signed [DATA_W-1:0] err_t;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int RANDOM_PHASES = 7;
  localparam int PHASE_ITEMS   = 200;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              wr_en;
  logic [INDEX_W-1:0] wr_index;
  logic [REGS_W-1:0] wr_data;
  logic              stall_on = 1'b0;
  logic              gaps_on = 1'b0;
  logic [THRESH_W-1:0] cur_thresh = THRESH_RESET;
  int                sent = 0;
  int                settings_count = 0;
  int                cycles = 0;
  int                mismatches;
  int                outstanding;
  int                compared;

  gspid_err_if err ();
  gspid_cmd_if cmd ();

  two_axis_gain_scheduled_incremental_pid dut (
    .clk      (clk),
    .rst      (rst),
    .err      (err),
    .cmd      (cmd),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  gspid_command_checker cmd_check (
    .clk         (clk),
    .rst         (rst),
    .err         (err),
    .cmd         (cmd),
    .wr_en       (wr_en),
    .wr_index    (wr_index),
    .wr_data     (wr_data),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .compared    (compared)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $error("run did not finish within %0d cycles", CYCLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic gains_t random_gains();
    gains_t g;
    case ($urandom_range(0, 5))
      0: g = gains_t'({$urandom, $urandom});
      1: begin
        g.kp = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        g.ki = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        g.kd = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      end
      default: begin
        // Gains within about +-1.0 keep the commands off the rails most of the time.
        g.kp = GAIN_W'($urandom_range(0, 8192)) - 16'sd4096;
        g.ki = GAIN_W'($urandom_range(0, 1024)) - 16'sd512;
        g.kd = GAIN_W'($urandom_range(0, 4096)) - 16'sd2048;
      end
    endcase
    return g;
  endfunction

  function automatic logic [THRESH_W-1:0] random_threshold();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2, 3: return THRESH_W'($urandom_range(0, 1024));
      default: return THRESH_W'($urandom);
    endcase
  endfunction

  // Errors cluster around the threshold so both gain sets and the tie are hit.
  function automatic err_t random_error(input logic [THRESH_W-1:0] thr);
    int m;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: m = $urandom;
      4, 5, 6: begin
        m = int'(thr) + int'($urandom_range(0, 2)) - 1;
        if ($urandom_range(0, 1) == 1) m = -m;
      end
      7: begin
        case ($urandom_range(0, 4))
          0: m = 32767;
          1: m = -32768;
          2: m = 0;
          3: m = -1;
          default: m = 1;
        endcase
      end
      default: m = int'($urandom_range(0, 1024)) - 512;
    endcase
    return err_t'(m);
  endfunction

  // Ends at the edge where the beat is taken, with valid still high.
  task automatic send_errors(input err_t pe, input err_t ye);
    int gap;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      err.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    err.valid       <= 1'b1;
    err.pitch_error <= pe;
    err.yaw_error   <= ye;
    @(posedge clk);
    while (!err.ready) @(posedge clk);
    sent++;
  endtask

  task automatic wait_drained();
    err.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [REGS_W-1:0] data);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(posedge clk);
  endtask

  task automatic program_gains(input logic [THRESH_W-1:0] thr, input gains_t pf,
                               input gains_t pn, input gains_t yf, input gains_t yn);
    logic [REGS_W-1:0] junk;
    wait_drained();
    junk = REGS_W'({$urandom, $urandom});
    // Bits above the threshold's width must be dropped by the block.
    write_reg(REG_THRESHOLD, {junk[REGS_W-1:THRESH_W], thr});
    write_reg(REG_PITCH_FAR, pf);
    write_reg(REG_PITCH_NEAR, pn);
    write_reg(REG_YAW_FAR, yf);
    write_reg(REG_YAW_NEAR, yn);
    // An index past the last register is ignored.
    write_reg(INDEX_W'($urandom_range(REG_YAW_NEAR + 1, (1 << INDEX_W) - 1)),
              REGS_W'({$urandom, $urandom}));
    wr_en <= 1'b0;
    cur_thresh = thr;
    settings_count++;
  endtask

  initial begin : ready_driver
    int hold;
    hold = 0;
    cmd.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        cmd.ready <= 1'b0;
      end else if (hold > 0) begin
        hold--;
        cmd.ready <= 1'b0;
      end else if (stall_on && $urandom_range(0, 2) == 0) begin
        hold = pick_gap();
        cmd.ready <= 1'b0;
      end else begin
        cmd.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    gains_t rails_pos;
    gains_t rails_neg;
    gains_t mild;
    gains_t mild_neg;
    err.valid       <= 1'b0;
    err.pitch_error <= '0;
    err.yaw_error   <= '0;
    wr_en           <= 1'b0;
    wr_index        <= '0;
    wr_data         <= '0;
    rails_pos = '{kd: 16'sh7FFF, ki: 16'sh7FFF, kp: 16'sh7FFF};
    rails_neg = '{kd: 16'sh8000, ki: 16'sh8000, kp: 16'sh8000};
    mild      = '{kd: 16'sh0800, ki: 16'sh0200, kp: 16'sh1000};
    mild_neg  = '{kd: 16'shFF00, ki: 16'sh0100, kp: 16'shF000};
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // With gains at their reset value of zero every command stays zero.
    send_errors(16'sd100, -16'sd100);
    send_errors(-16'sd32768, 16'sd32767);

    program_gains(THRESH_RESET, rails_pos, mild, rails_neg, mild_neg);
    send_errors(16'sd0, 16'sd0);
    send_errors(16'sd256, 16'sd256);     // equal to the threshold: near set
    send_errors(16'sd257, 16'sd257);
    send_errors(-16'sd256, -16'sd256);
    send_errors(-16'sd257, -16'sd257);
    send_errors(16'sd32767, -16'sd32768);
    send_errors(-16'sd32768, 16'sd32767);
    send_errors(16'sd32767, 16'sd32767); // drives the commands into saturation
    send_errors(16'sd32767, 16'sd32767);
    send_errors(-16'sd32768, -16'sd32768);
    send_errors(-16'sd32768, -16'sd32768);
    send_errors(16'sd1, -16'sd1);
    send_errors(-16'sd1, 16'sd1);

    program_gains('0, mild, rails_neg, mild_neg, rails_pos);
    send_errors(16'sd0, 16'sd0);         // zero error is not above a zero threshold
    send_errors(16'sd1, -16'sd1);
    send_errors(-16'sd32768, 16'sd32767);
    send_errors(16'sd0, 16'sd0);

    // The most negative error is above even the largest threshold.
    program_gains('1, rails_neg, rails_pos, mild, rails_pos);
    send_errors(16'sd32767, -16'sd32767);
    send_errors(-16'sd32768, -16'sd32768);
    send_errors(16'sd32767, 16'sd32767);
    send_errors(-16'sd32767, 16'sd0);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      program_gains(random_threshold(), random_gains(), random_gains(),
                    random_gains(), random_gains());
      gaps_on  <= (phase != 0);
      stall_on <= (phase > 1);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_errors(random_error(cur_thresh), random_error(cur_thresh));
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    $display("Sent %0d error beats and checked %0d command beats under %0d gain settings.",
             sent, compared, settings_count);
    $display("Covered both threshold rails, the equal-threshold tie, rail gains and saturation.");
    if (mismatches == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/gspid_pkg.sv
rtl/gspid_ifs.sv
rtl/gspid_cfg.sv
rtl/gspid_axis.sv
rtl/two_axis_gain_scheduled_incremental_pid.sv
dv/gspid_command_checker.sv
dv/two_axis_gain_scheduled_incremental_pid_test.sv
